[hw/rtl/alti_pkg.sv]
// ----------------------------------------------------------------------------
// alti_pkg
// Shared types and constants for the arc-length table and inverse lookup.
// ----------------------------------------------------------------------------
package alti_pkg;

   localparam int LEN_W    = 40;
   localparam int TGT_W    = LEN_W + 1;
   localparam int T_W      = 17;
   localparam int COORD_W  = 32;
   localparam int SQRT_RW  = 33;
   localparam int DIV_NW   = 57;
   localparam int DIV_DW   = 40;
   localparam int DIV_CW   = $clog2(DIV_NW + 1);

   localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
   localparam logic [T_W-1:0]   ONE_Q16 = 17'h10000;

   localparam logic [1:0] OP_FIRST = 2'd0;
   localparam logic [1:0] OP_NEXT  = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;
   localparam logic [1:0] OP_RSVD  = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_SHORT = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic              start;
      logic [DIV_NW-1:0] num;
      logic [DIV_DW-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DIV_NW-1:0] quo;
   } div_rsp_type;

   typedef enum logic [14:0] {
      S_IDLE     = 15'b000000000000001,
      S_SQUARE   = 15'b000000000000010,
      S_SUM      = 15'b000000000000100,
      S_ROOT     = 15'b000000000001000,
      S_APPEND   = 15'b000000000010000,
      S_MUL      = 15'b000000000100000,
      S_TARGET   = 15'b000000001000000,
      S_SRCH_RD  = 15'b000000010000000,
      S_SRCH_CMP = 15'b000000100000000,
      S_HI_RD    = 15'b000001000000000,
      S_HI_CMP   = 15'b000010000000000,
      S_NX_CMP   = 15'b000100000000000,
      S_DIV_F    = 15'b001000000000000,
      S_DIV_T    = 15'b010000000000000,
      S_DONE     = 15'b100000000000000
   } state_type;

endpackage

[hw/rtl/arc_length_table_inverse.sv]
// ----------------------------------------------------------------------------
// arc_length_table_inverse
// Cumulative arc-length table built from sample points, with inverse lookup
// of the curve parameter t by binary search and linear interpolation.
// ----------------------------------------------------------------------------
//  channel  | ports              | content
//  request  | req_t*  (in)       | tuser: op; tdata: point_x, point_y, u_fraction,
//           |                    |        target_distance
//  response | rsp_t*  (out)      | tuser: status; tdata: t_value, total_length
//
//  First point and unused op go straight to the response stage. Next point
//  waits on the bit-serial square root (33 steps plus start and finish).
//  Query: a read and a compare per search probe (up to log2(MAX_ENTRIES)+1
//  probes), then serial divisions: none when t clamps, one on an exact hit,
//  two otherwise.
//  One request is in work at a time; a new one is taken while a response waits.
//  Reset empties the table; entries are written before they are read.
// ----------------------------------------------------------------------------
module arc_length_table_inverse
   import alti_pkg::*;
#(
   parameter int MAX_ENTRIES = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [1:0]   req_tuser,   // [1:0] op
   input  logic [127:0] req_tdata,   // [31:0] point_x, [63:32] point_y,
                                     // [80:64] u_fraction, [120:81] target_distance
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [1:0]   rsp_tuser,   // [1:0] status
   output logic [63:0]  rsp_tdata    // [16:0] t_value, [56:17] total_length
);

   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int SW = CW + 1;

   state_type state_ff, state_in;

   logic [CW-1:0]            count_ff, count_in;
   logic [LEN_W-1:0]         last_ff, last_in;
   logic signed [COORD_W-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic signed [COORD_W-1:0] x_ff, x_in, y_ff, y_in;
   logic [T_W-1:0]           u_ff, u_in;
   logic [COORD_W:0]         adx_ff, adx_in, ady_ff, ady_in;
   logic [2*SQRT_RW-1:0]     sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [T_W+19:0]          plo_ff, plo_in, phi_ff, phi_in;
   logic [TGT_W-1:0]         target_ff, target_in;
   logic signed [SW-1:0]     lo_ff, lo_in, hi_ff, hi_in;
   logic [AW-1:0]            mid_ff, mid_in;
   logic [LEN_W-1:0]         before_ff, before_in;
   logic [T_W-1:0]           t_ff, t_in;
   logic [1:0]               status_ff, status_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [T_W-1:0]           rsp_t_ff, rsp_t_in;
   logic [LEN_W-1:0]         rsp_len_ff, rsp_len_in;
   logic [1:0]               rsp_st_ff, rsp_st_in;

   logic                     tbl_we;
   logic [AW-1:0]            tbl_waddr, tbl_raddr;
   logic [LEN_W-1:0]         tbl_wdata, tbl_rdata;
   logic                     sqrt_start, sqrt_done;
   logic [SQRT_RW-1:0]       sqrt_root;
   div_req_type              div_req;
   div_rsp_type              div_rsp;

   logic [1:0]               in_op;
   logic signed [COORD_W-1:0] in_x, in_y;
   logic [LEN_W-1:0]         in_dist;
   logic signed [COORD_W:0]  dx, dy;
   logic [LEN_W:0]           sum_len;
   logic [T_W+39:0]          prod;
   logic signed [SW-1:0]     mid_s, hi_last;
   logic [TGT_W-1:0]         rd_ext;
   logic [LEN_W-1:0]         seg;

   alti_table #(.DEPTH(MAX_ENTRIES), .AW(AW)) u_table (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_waddr),
      .wr_data (tbl_wdata),
      .rd_addr (tbl_raddr),
      .rd_data (tbl_rdata)
   );

   alti_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sqx_ff + sqy_ff),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   alti_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      in_op   = req_tuser;
      in_x    = $signed(req_tdata[31:0]);
      in_y    = $signed(req_tdata[63:32]);
      in_dist = req_tdata[120:81];
      dx      = {in_x[COORD_W-1], in_x} - {prev_x_ff[COORD_W-1], prev_x_ff};
      dy      = {in_y[COORD_W-1], in_y} - {prev_y_ff[COORD_W-1], prev_y_ff};
      sum_len = {1'b0, last_ff} + (LEN_W+1)'(sqrt_root);
      prod    = (T_W+40)'(plo_ff) + ((T_W+40)'(phi_ff) << 20);
      mid_s   = lo_ff + ((hi_ff - lo_ff) >>> 1);
      hi_last = $signed({1'b0, count_ff}) - SW'(1);
      rd_ext  = {1'b0, tbl_rdata};
      seg     = tbl_rdata - before_ff;

      state_in     = state_ff;
      count_in     = count_ff;
      last_in      = last_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      u_in         = u_ff;
      adx_in       = adx_ff;
      ady_in       = ady_ff;
      sqx_in       = sqx_ff;
      sqy_in       = sqy_ff;
      plo_in       = plo_ff;
      phi_in       = phi_ff;
      target_in    = target_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      before_in    = before_ff;
      t_in         = t_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_t_in     = rsp_t_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_st_in    = rsp_st_ff;
      tbl_we       = 1'b0;
      tbl_waddr    = '0;
      tbl_wdata    = '0;
      tbl_raddr    = '0;
      sqrt_start   = 1'b0;
      div_req      = '0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               t_in      = '0;
               status_in = ST_OK;
               x_in      = in_x;
               y_in      = in_y;
               u_in      = req_tdata[80:64];
               adx_in    = dx[COORD_W] ? (COORD_W+1)'(-dx) : (COORD_W+1)'(dx);
               ady_in    = dy[COORD_W] ? (COORD_W+1)'(-dy) : (COORD_W+1)'(dy);
               lo_in     = '0;
               hi_in     = hi_last;
               target_in = {1'b0, in_dist};
               state_in  = S_DONE;
               if (in_op == OP_FIRST || (in_op == OP_NEXT && count_ff == '0)) begin
                  // restart the table at a single zero entry
                  tbl_we    = 1'b1;
                  prev_x_in = in_x;
                  prev_y_in = in_y;
                  count_in  = CW'(1);
                  last_in   = '0;
               end else if (in_op == OP_NEXT) begin
                  if (count_ff >= CW'(MAX_ENTRIES)) begin
                     status_in = ST_FULL;
                  end else begin
                     state_in = S_SQUARE;
                  end
               end else if (in_op == OP_QUERY) begin
                  if (count_ff < CW'(2)) begin
                     status_in = ST_SHORT;
                  end else if (in_dist == '0) begin
                     state_in = S_MUL;
                  end else begin
                     state_in = S_SRCH_RD;
                  end
               end
            end
         end
         S_SQUARE: begin
            sqx_in   = (2*SQRT_RW)'(adx_ff * adx_ff);
            sqy_in   = (2*SQRT_RW)'(ady_ff * ady_ff);
            state_in = S_SUM;
         end
         S_SUM: begin
            sqrt_start = 1'b1;
            state_in   = S_ROOT;
         end
         S_ROOT: begin
            if (sqrt_done) begin
               state_in = S_APPEND;
            end
         end
         S_APPEND: begin
            tbl_we    = 1'b1;
            tbl_waddr = count_ff[AW-1:0];
            tbl_wdata = sum_len[LEN_W] ? LEN_MAX : sum_len[LEN_W-1:0];
            last_in   = tbl_wdata;
            count_in  = count_ff + CW'(1);
            prev_x_in = x_ff;
            prev_y_in = y_ff;
            state_in  = S_DONE;
         end
         S_MUL: begin
            plo_in   = (T_W+20)'(u_ff * last_ff[19:0]);
            phi_in   = (T_W+20)'(u_ff * last_ff[39:20]);
            state_in = S_TARGET;
         end
         S_TARGET: begin
            target_in = prod[T_W+39:16];
            state_in  = S_SRCH_RD;
         end
         S_SRCH_RD: begin
            mid_in    = mid_s[AW-1:0];
            tbl_raddr = mid_s[AW-1:0];
            state_in  = S_SRCH_CMP;
         end
         S_SRCH_CMP: begin
            state_in = S_HI_RD;
            if (rd_ext < target_ff) begin
               lo_in = $signed(SW'(mid_ff)) + SW'(1);
               if (lo_in <= hi_ff) begin
                  state_in = S_SRCH_RD;
               end
            end else if (rd_ext > target_ff) begin
               hi_in = $signed(SW'(mid_ff)) - SW'(1);
               if (lo_ff <= hi_in) begin
                  state_in = S_SRCH_RD;
               end
            end else begin
               hi_in = $signed(SW'(mid_ff));
            end
         end
         S_HI_RD: begin
            if (hi_ff < 0) begin
               t_in     = '0;
               state_in = S_DONE;
            end else begin
               tbl_raddr = hi_ff[AW-1:0];
               state_in  = S_HI_CMP;
            end
         end
         S_HI_CMP: begin
            before_in = tbl_rdata;
            if (rd_ext == target_ff) begin
               div_req.start = 1'b1;
               div_req.num   = DIV_NW'(hi_ff[AW-1:0]) << 16;
               div_req.den   = DIV_DW'(count_ff - CW'(1));
               state_in      = S_DIV_T;
            end else if (hi_ff >= hi_last) begin
               t_in     = ONE_Q16;
               state_in = S_DONE;
            end else begin
               tbl_raddr = hi_ff[AW-1:0] + AW'(1);
               state_in  = S_NX_CMP;
            end
         end
         S_NX_CMP: begin
            div_req.start = 1'b1;
            if (seg != '0) begin
               div_req.num = DIV_NW'(target_ff - {1'b0, before_ff}) << 16;
               div_req.den = seg;
               state_in    = S_DIV_F;
            end else begin
               div_req.num = DIV_NW'(hi_ff[AW-1:0]) << 16;
               div_req.den = DIV_DW'(count_ff - CW'(1));
               state_in    = S_DIV_T;
            end
         end
         S_DIV_F: begin
            if (div_rsp.done) begin
               div_req.start = 1'b1;
               div_req.num   = (DIV_NW'(hi_ff[AW-1:0]) << 16) + DIV_NW'(div_rsp.quo[T_W-1:0]);
               div_req.den   = DIV_DW'(count_ff - CW'(1));
               state_in      = S_DIV_T;
            end
         end
         S_DIV_T: begin
            if (div_rsp.done) begin
               t_in = (div_rsp.quo > DIV_NW'(ONE_Q16)) ? ONE_Q16 : div_rsp.quo[T_W-1:0];
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_t_in     = t_ff;
               rsp_len_in   = last_ff;
               rsp_st_in    = status_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         last_ff      <= '0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         last_ff      <= last_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff      <= x_in;
      y_ff      <= y_in;
      u_ff      <= u_in;
      adx_ff    <= adx_in;
      ady_ff    <= ady_in;
      sqx_ff    <= sqx_in;
      sqy_ff    <= sqy_in;
      plo_ff    <= plo_in;
      phi_ff    <= phi_in;
      target_ff <= target_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mid_ff    <= mid_in;
      before_ff <= before_in;
      t_ff      <= t_in;
      status_ff <= status_in;
      rsp_t_ff  <= rsp_t_in;
      rsp_len_ff <= rsp_len_in;
      rsp_st_ff <= rsp_st_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_st_ff;
   assign rsp_tdata  = {7'b0, rsp_len_ff, rsp_t_ff};

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ENTRIES))
      else $error("entry count past table depth");

   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) && rsp_st_ff == ST_FULL |-> count_ff == CW'(MAX_ENTRIES))
      else $error("full status with room left in table");

   a_t_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_t_ff <= ONE_Q16)
      else $error("t above one");

   a_empty_len: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> last_ff == '0)
      else $error("nonzero length on empty table");

endmodule

[hw/rtl/alti_table.sv]
// ----------------------------------------------------------------------------
// alti_table
// Cumulative length memory: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module alti_table
   import alti_pkg::*;
#(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [LEN_W-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [LEN_W-1:0] rd_data
);

   logic [LEN_W-1:0] mem [DEPTH];
   logic [LEN_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/alti_sqrt.sv]
// ----------------------------------------------------------------------------
// alti_sqrt
// Integer square root, one result bit per cycle, floor of the true root.
// ----------------------------------------------------------------------------
module alti_sqrt
   import alti_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [2*SQRT_RW-1:0]   radicand,
   output logic                   done,
   output logic [SQRT_RW-1:0]     root
);

   localparam int CW = $clog2(SQRT_RW + 1);

   logic                   busy_ff, busy_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic [2*SQRT_RW-1:0]   rad_ff, rad_in;
   logic [SQRT_RW+1:0]     rem_ff, rem_in;
   logic [SQRT_RW-1:0]     root_ff, root_in;
   logic [SQRT_RW+3:0]     cur;
   logic [SQRT_RW+3:0]     trial;
   logic                   ge;

   always_comb begin
      cur   = {rem_ff, rad_ff[2*SQRT_RW-1 -: 2]};
      trial = (SQRT_RW+4)'({root_ff, 2'b01});
      ge    = (cur >= trial);
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(SQRT_RW);
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            cnt_in  = cnt_ff - CW'(1);
            rad_in  = rad_ff << 2;
            rem_in  = ge ? (SQRT_RW+2)'(cur - trial) : (SQRT_RW+2)'(cur);
            root_in = {root_ff[SQRT_RW-2:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = busy_ff && (cnt_ff == '0);
   assign root = root_ff;

endmodule

[hw/rtl/alti_div.sv]
// ----------------------------------------------------------------------------
// alti_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module alti_div
   import alti_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic              busy_ff, busy_in;
   logic [DIV_CW-1:0] cnt_ff, cnt_in;
   logic [DIV_NW-1:0] quo_ff, quo_in;
   logic [DIV_DW-1:0] rem_ff, rem_in;
   logic [DIV_DW-1:0] den_ff, den_in;
   logic [DIV_DW:0]   shifted;
   logic              ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_NW-1]};
      ge      = (shifted >= {1'b0, den_ff});
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CW'(DIV_NW);
         quo_in  = req.num;
         rem_in  = '0;
         den_in  = req.den;
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - DIV_CW'(1);
            rem_in = ge ? DIV_DW'(shifted - {1'b0, den_ff}) : DIV_DW'(shifted);
            quo_in = {quo_ff[DIV_NW-2:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign rsp.done = busy_ff && (cnt_ff == '0);
   assign rsp.quo  = quo_ff;

endmodule

[test/arc_length_table_inverse_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// arc_length_table_inverse_checker
// Watches the request and response channels, keeps its own arc-length table,
// predicts each response and compares it field by field.
// ----------------------------------------------------------------------------
module arc_length_table_inverse_checker
   import alti_pkg::*;
#(
   parameter int MAX_ENTRIES = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [1:0]   req_tuser,
   input  logic [127:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [1:0]   rsp_tuser,
   input  logic [63:0]  rsp_tdata,
   output int           fail_count,
   output int           pending_count
);

   typedef struct packed {
      logic [T_W-1:0]   t_value;
      logic [LEN_W-1:0] total_length;
      logic [1:0]       status;
   } answer_type;

   logic [LEN_W-1:0] arc_table [MAX_ENTRIES];
   int               n_entries;
   logic signed [COORD_W-1:0] last_x, last_y;
   answer_type       answer_q [$];

   assign pending_count = answer_q.size();

   function automatic logic [63:0] isqrt(input logic [64:0] s);
      logic [63:0]  r;
      logic [63:0]  c;
      logic [127:0] sq;
      r = 0;
      for (int b = 33; b >= 0; b--) begin
         c  = r | (64'd1 << b);
         sq = c * c;
         if (sq <= {63'd0, s}) r = c;
      end
      return r;
   endfunction

   task automatic predict_request(input logic [1:0] op, input logic [127:0] d);
      logic signed [COORD_W-1:0] x, y;
      logic [16:0]      u;
      logic [LEN_W-1:0] tgt_dist, total, len_lo, len_hi;
      logic [LEN_W:0]   target;
      logic [63:0]      dx, dy, seg, frac, t;
      logic [64:0]      sum;
      logic [41:0]      acc;
      logic [57:0]      prod;
      logic [1:0]       st;
      int lo, hi, mid;
      x = d[31:0];
      y = d[63:32];
      u = d[80:64];
      tgt_dist = d[120:81];
      t = 0;
      st = ST_OK;
      if (op == OP_NEXT && n_entries == 0) op = OP_FIRST;
      if (op == OP_FIRST) begin
         last_x = x;
         last_y = y;
         arc_table[0] = '0;
         n_entries = 1;
      end else if (op == OP_NEXT) begin
         if (n_entries >= MAX_ENTRIES) begin
            st = ST_FULL;
         end else begin
            dx = $signed(x) - $signed(last_x);
            dy = $signed(y) - $signed(last_y);
            if (dx[63]) dx = -dx;
            if (dy[63]) dy = -dy;
            sum = {1'b0, dx * dx} + {1'b0, dy * dy};
            seg = isqrt(sum);
            acc = arc_table[n_entries-1] + seg;
            arc_table[n_entries] = (acc > LEN_MAX) ? LEN_MAX : acc[LEN_W-1:0];
            n_entries++;
            last_x = x;
            last_y = y;
         end
      end else if (op == OP_QUERY) begin
         if (n_entries < 2) begin
            st = ST_SHORT;
         end else begin
            total = arc_table[n_entries-1];
            prod = u * total;
            target = (tgt_dist != 0) ? {1'b0, tgt_dist} : prod[56:16];
            lo = 0;
            hi = n_entries - 1;
            while (lo <= hi) begin
               mid = lo + (hi - lo) / 2;
               if (arc_table[mid] < target) lo = mid + 1;
               else if (arc_table[mid] > target) hi = mid - 1;
               else begin
                  hi = mid;
                  break;
               end
            end
            if (hi < 0) t = 0;
            else if (arc_table[hi] == target) t = (64'(hi) << 16) / (n_entries - 1);
            else if (hi >= n_entries - 1) t = ONE_Q16;
            else begin
               len_lo = arc_table[hi];
               len_hi = arc_table[hi+1];
               frac = (len_hi != len_lo) ?
                      (64'(target - len_lo) << 16) / 64'(len_hi - len_lo) : 0;
               t = ((64'(hi) << 16) + frac) / (n_entries - 1);
            end
            if (t > ONE_Q16) t = ONE_Q16;
         end
      end
      answer_q.push_back('{t_value: t[16:0],
                           total_length: n_entries ? arc_table[n_entries-1] : '0,
                           status: st});
   endtask

   always @(posedge clock) begin
      answer_type exp_a;
      int errs;
      errs = 0;
      if (reset) begin
         n_entries = 0;
         last_x = '0;
         last_y = '0;
         fail_count <= 0;
         answer_q.delete();
      end else begin
         if (req_tvalid && req_tready) predict_request(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (answer_q.size() == 0) begin
               $error("unexpected response t=%0d len=%0d st=%0d",
                      rsp_tdata[16:0], rsp_tdata[56:17], rsp_tuser);
               errs++;
            end else begin
               exp_a = answer_q.pop_front();
               if (rsp_tdata[16:0] !== exp_a.t_value) begin
                  $error("t_value expected %0d actual %0d", exp_a.t_value, rsp_tdata[16:0]);
                  errs++;
               end
               if (rsp_tdata[56:17] !== exp_a.total_length) begin
                  $error("total_length expected %0d actual %0d",
                         exp_a.total_length, rsp_tdata[56:17]);
                  errs++;
               end
               if (rsp_tuser !== exp_a.status) begin
                  $error("status expected %0d actual %0d", exp_a.status, rsp_tuser);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
      end
   end

endmodule

[test/arc_length_table_inverse_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// arc_length_table_inverse_tb
// Drives point loads and inverse queries with random flow control, including
// a long response hold-off and a table filled past capacity; the checker
// predicts every response.
// ----------------------------------------------------------------------------
module arc_length_table_inverse_tb
   import alti_pkg::*;
();

   localparam int ENTRY_LIMIT = 256;
   localparam int RANDOM_REQUESTS = 1520;
   localparam int IDLE_LIMIT = 20000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [1:0]   req_tuser = '0;
   logic [127:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [1:0]   rsp_tuser;
   logic [63:0]  rsp_tdata;
   int           fail_count;
   int           pending_count;
   int           idle_cycles = 0;
   bit           quiet_tail = 1'b0;
   bit           hold_off = 1'b0;

   always #5 clock = ~clock;

   arc_length_table_inverse #(.MAX_ENTRIES(ENTRY_LIMIT)) u_top (.*);

   arc_length_table_inverse_checker #(.MAX_ENTRIES(ENTRY_LIMIT)) u_checker (.*);

   // watchdog on accepted traffic
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL arc_length_table_inverse");
         $finish;
      end
   end

   // receiver: random stall bursts, one long hold-off on request
   initial begin
      int n;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_off = 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 5);
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return $urandom;
         default: return 32'($signed($urandom_range(0, 400000)) - 200000);
      endcase
   endfunction

   task automatic send_request(input logic [1:0] op, input logic [31:0] x,
                               input logic [31:0] y, input logic [16:0] u,
                               input logic [39:0] tgt_dist);
      int n;
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         n = $urandom_range(1, 5);
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {7'd0, tgt_dist, u, y, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_query();
      logic [39:0] tgt_dist;
      case ($urandom_range(0, 4))
         0: tgt_dist = '0;
         1: tgt_dist = 40'({$urandom, $urandom});
         2: tgt_dist = 40'hFFFFFFFFFF;
         default: tgt_dist = 40'($urandom_range(0, 2000000) << $urandom_range(0, 8));
      endcase
      send_request(OP_QUERY, $urandom, $urandom,
                   $urandom_range(0, 3) == 0 ? 17'($urandom) : 17'($urandom_range(0, 65536)),
                   tgt_dist);
   endtask

   initial begin
      int n_points;
      int sent;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: short-table queries, next point on empty table, extremes
      send_request(OP_QUERY, '0, '0, 17'd65536, '0);
      send_request(OP_NEXT, 32'h7FFFFFFF, 32'h7FFFFFFF, '0, '0);
      send_request(OP_QUERY, '0, '0, '0, 40'd5);
      send_request(OP_NEXT, 32'h80000000, 32'h80000000, '0, '0);
      send_request(OP_NEXT, 32'h7FFFFFFF, 32'h7FFFFFFF, '0, '0);
      send_request(OP_NEXT, 32'h7FFFFFFF, 32'h7FFFFFFF, '0, '0);
      send_request(OP_QUERY, '0, '0, 17'd65536, '0);
      send_request(OP_QUERY, '0, '0, 17'h1FFFF, '0);
      send_request(OP_QUERY, '0, '0, '0, 40'hFFFFFFFFFF);
      send_request(OP_RSVD, 32'hFFFFFFFF, 32'hFFFFFFFF, 17'h1FFFF, 40'hFFFFFFFFFF);
      send_request(OP_FIRST, '0, '0, '0, '0);
      send_request(OP_NEXT, 32'h00030000, 32'h00040000, '0, '0);
      send_request(OP_NEXT, 32'h00030000, 32'h00040000, '0, '0);
      send_request(OP_NEXT, 32'h00060000, 32'h00080000, '0, '0);
      send_request(OP_QUERY, '0, '0, '0, 40'h50000);
      send_request(OP_QUERY, '0, '0, '0, 40'h70000);
      send_request(OP_QUERY, '0, '0, 17'd32768, '0);
      send_request(OP_QUERY, '0, '0, 17'd0, '0);

      // saturate: fill past capacity while the receiver holds off
      hold_off = 1'b1;
      send_request(OP_FIRST, 32'h80000000, 32'h80000000, '0, '0);
      for (int i = 0; i < ENTRY_LIMIT + 2; i++)
         send_request(OP_NEXT, (i % 2) ? 32'h80000000 : 32'h7FFFFFFF,
                      (i % 2) ? 32'h80000000 : 32'h7FFFFFFF, '0, '0);
      send_request(OP_QUERY, '0, '0, 17'd1000, '0);

      // random: curves of random length, then queries, some noise
      sent = 0;
      while (sent < RANDOM_REQUESTS) begin
         if (sent > RANDOM_REQUESTS - 150) quiet_tail = 1'b1;
         if ($urandom_range(0, 9) == 0) begin
            send_request($urandom_range(0, 3), $urandom, $urandom, 17'($urandom), '0);
            sent++;
         end else begin
            n_points = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 260)
                                                    : $urandom_range(1, 12);
            send_request(OP_FIRST, rand_coord(), rand_coord(), 17'($urandom), '0);
            for (int i = 1; i < n_points; i++)
               send_request(OP_NEXT, rand_coord(), rand_coord(), 17'($urandom), '0);
            sent += n_points;
            repeat ($urandom_range(2, 8)) begin
               send_query();
               sent++;
            end
         end
      end
      req_tvalid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0) $display("PASS arc_length_table_inverse");
      else $display("FAIL arc_length_table_inverse");
      $finish;
   end

endmodule

[files.f]
hw/rtl/alti_pkg.sv
hw/rtl/alti_table.sv
hw/rtl/alti_sqrt.sv
hw/rtl/alti_div.sv
hw/rtl/arc_length_table_inverse.sv
test/arc_length_table_inverse_checker.sv
test/arc_length_table_inverse_tb.sv
